// File: rtl/ircnt_pkg.sv
// ircnt_pkg: shared constants, codes and payload types of the interval reference-count table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ircnt_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int HEAP_UNITS  = 2048;
	localparam int UNIT_SHIFT  = 8;
	localparam int COUNT_BITS  = 8;

	localparam int UNIT_W  = 12;                          // stored interval bound
	localparam int EXT_W   = 13;                          // request end before clipping
	localparam int IDX_W   = $clog2(MAX_ENTRIES);
	localparam int USED_W  = $clog2(MAX_ENTRIES + 1);
	localparam int EMIT_W  = $clog2(MAX_ENTRIES + 2);
	localparam int REF_W   = 20;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_REL = 2'd1,
		OP_CHK = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2,
		ST_ZERO = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [18:0] start_byte;
		logic [19:0] size_bytes;
	} req_t;

	typedef struct packed {
		logic [7:0]       ref_min;
		logic [7:0]       ref_max;
		logic [1:0]       status;
		logic             block_matches;
		logic [REF_W-1:0] referenced_bytes;
	} rsp_t;

	typedef struct packed {
		logic [UNIT_W-1:0]     lo;
		logic [UNIT_W-1:0]     hi;
		logic [COUNT_BITS-1:0] cnt;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// write side of the two table banks
	typedef struct packed {
		logic             we_a;
		logic             we_b;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

endpackage
`default_nettype wire

// File: rtl/ircnt_if.sv
// ircnt_if: request and response channels with valid/ready handshake
// depends on ircnt_pkg
`timescale 1ns / 1ps
`default_nettype none
interface ircnt_req_if;
	logic             valid;
	logic             ready;
	ircnt_pkg::req_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface ircnt_rsp_if;
	logic             valid;
	logic             ready;
	ircnt_pkg::rsp_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/ircnt_ram.sv
// ircnt_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ircnt_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/ircnt_seq.sv
// ircnt_seq: sequencer that merges a request range against the active bank and
// rebuilds the table into the other bank; depends on ircnt_pkg
`timescale 1ns / 1ps
`default_nettype none
module ircnt_seq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start_valid,
	output logic                                start_ready,
	input  wire ircnt_pkg::req_t                req,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output ircnt_pkg::rsp_t                     res,
	output logic [ircnt_pkg::IDX_W-1:0]         rd_addr,
	input  wire ircnt_pkg::entry_t              rd_data_a,
	input  wire ircnt_pkg::entry_t              rd_data_b,
	output ircnt_pkg::mem_wr_t                  wr
);
	typedef enum logic [2:0] {S_IDLE, S_RD, S_EVAL, S_EMIT, S_TAIL, S_FIN} state_t;
	typedef enum logic [1:0] {M_PRE, M_CHECK, M_BUILD} mode_t;

	typedef struct packed {
		logic                              hit;
		logic [ircnt_pkg::COUNT_BITS-1:0]  mn;
		logic [ircnt_pkg::COUNT_BITS-1:0]  mx;
	} touch_t;

	function automatic touch_t touch_upd(touch_t t, logic [ircnt_pkg::COUNT_BITS-1:0] c);
		touch_t r;
		r     = t;
		r.hit = 1'b1;
		if (!t.hit || c < t.mn) r.mn = c;
		if (!t.hit || c > t.mx) r.mx = c;
		return r;
	endfunction

	localparam logic [ircnt_pkg::EXT_W-1:0] HEAP_END = ircnt_pkg::EXT_W'(ircnt_pkg::HEAP_UNITS);
	localparam logic [20:0] ROUND = 21'((1 << ircnt_pkg::UNIT_SHIFT) - 1);
	localparam logic [ircnt_pkg::COUNT_BITS-1:0] ONE = ircnt_pkg::COUNT_BITS'(1);

	state_t                             state_q;
	mode_t                              mode_q;
	logic                               adding_q;
	logic                               bank_q;
	logic [ircnt_pkg::USED_W-1:0]       used_q;
	logic [ircnt_pkg::USED_W-1:0]       k_q;
	logic [ircnt_pkg::UNIT_W-1:0]       sum_q;
	logic [ircnt_pkg::UNIT_W-1:0]       nsum_q;
	logic [ircnt_pkg::UNIT_W-1:0]       s_q;
	logic [ircnt_pkg::EXT_W-1:0]        e_q;
	logic [ircnt_pkg::UNIT_W-1:0]       pos_q;
	logic [ircnt_pkg::EMIT_W-1:0]       n_q;
	touch_t                             tch_q;
	logic                               match_q;
	logic [ircnt_pkg::COUNT_BITS-1:0]   mcnt_q;
	ircnt_pkg::status_t                 pre_q;
	ircnt_pkg::entry_t                  pc_q [4];
	logic [3:0]                         pend_q;

	// request decode
	logic [ircnt_pkg::UNIT_W-1:0] d_s;
	logic [ircnt_pkg::EXT_W-1:0]  d_su, d_e, d_ec;
	always_comb begin
		d_s  = ircnt_pkg::UNIT_W'(req.start_byte >> ircnt_pkg::UNIT_SHIFT);
		d_su = ircnt_pkg::EXT_W'((21'(req.size_bytes) + ROUND) >> ircnt_pkg::UNIT_SHIFT);
		d_e  = ircnt_pkg::EXT_W'(d_s) + d_su;
		d_ec = (d_e > HEAP_END) ? HEAP_END : d_e;
	end

	// merge of one stored entry against the range
	ircnt_pkg::entry_t            rd;
	logic [ircnt_pkg::UNIT_W-1:0] lo_v, hi_v, gap_hi;
	logic [ircnt_pkg::COUNT_BITS-1:0] nc;
	logic                         gap_v, ovl;
	touch_t                       t_gap, t_all;
	logic [3:0]                   pend_v;
	always_comb begin
		rd     = bank_q ? rd_data_b : rd_data_a;
		lo_v   = (rd.lo > s_q) ? rd.lo : s_q;
		hi_v   = ({1'b0, rd.hi} < e_q) ? rd.hi : e_q[ircnt_pkg::UNIT_W-1:0];
		gap_hi = ({1'b0, rd.lo} < e_q) ? rd.lo : e_q[ircnt_pkg::UNIT_W-1:0];
		gap_v  = adding_q && ({1'b0, pos_q} < e_q) && (rd.lo > pos_q);
		ovl    = lo_v < hi_v;
		if (adding_q) begin
			nc = (rd.cnt < ircnt_pkg::COUNT_MAX) ? rd.cnt + ONE : rd.cnt;
		end else begin
			nc = (rd.cnt != '0) ? rd.cnt - ONE : '0;
		end
		t_gap  = gap_v ? touch_upd(tch_q, ONE) : tch_q;
		t_all  = ovl ? touch_upd(t_gap, nc) : t_gap;
		pend_v = {ovl && (hi_v < rd.hi), ovl && (nc != '0), ovl ? (rd.lo < lo_v) : 1'b1, gap_v};
	end

	// lowest pending piece
	logic [1:0] sel;
	always_comb begin
		sel = 2'd3;
		for (int i = 3; i >= 0; i--) begin
			if (pend_q[i]) sel = 2'(i);
		end
	end

	logic                     last_k;
	logic                     tail_v;
	logic                     full_v;
	logic                     commit;
	ircnt_pkg::entry_t        wdat;
	always_comb begin
		last_k = (k_q + ircnt_pkg::USED_W'(1)) == used_q;
		tail_v = adding_q && ({1'b0, pos_q} < e_q);
		full_v = n_q > ircnt_pkg::EMIT_W'(ircnt_pkg::MAX_ENTRIES);
		commit = (mode_q == M_BUILD) && !full_v && tch_q.hit;
		if (state_q == S_TAIL) begin
			wdat = '{lo: pos_q, hi: e_q[ircnt_pkg::UNIT_W-1:0], cnt: ONE};
		end else begin
			wdat = pc_q[sel];
		end
	end

	logic emit_now;
	assign emit_now = (state_q == S_EMIT) || ((state_q == S_TAIL) && tail_v);
	always_comb begin
		wr.addr = n_q[ircnt_pkg::IDX_W-1:0];
		wr.data = wdat;
		wr.we_a = emit_now && (n_q < ircnt_pkg::EMIT_W'(ircnt_pkg::MAX_ENTRIES)) && bank_q;
		wr.we_b = emit_now && (n_q < ircnt_pkg::EMIT_W'(ircnt_pkg::MAX_ENTRIES)) && !bank_q;
	end

	assign rd_addr     = k_q[ircnt_pkg::IDX_W-1:0];
	assign start_ready = state_q == S_IDLE;
	assign res_valid   = state_q == S_FIN;

	always_comb begin
		res.block_matches = 1'b0;
		res.ref_min       = '0;
		res.ref_max       = '0;
		res.status        = pre_q;
		case (mode_q)
			M_CHECK: begin
				res.block_matches = match_q;
				res.status        = match_q ? ircnt_pkg::ST_OK : ircnt_pkg::ST_NONE;
				res.ref_min       = mcnt_q;
				res.ref_max       = mcnt_q;
			end
			M_BUILD: begin
				if (full_v) begin
					res.status = ircnt_pkg::ST_FULL;
				end else if (tch_q.hit) begin
					res.status  = ircnt_pkg::ST_OK;
					res.ref_min = tch_q.mn;
					res.ref_max = tch_q.mx;
				end else begin
					res.status = ircnt_pkg::ST_NONE;
				end
			end
			default: ;
		endcase
		res.referenced_bytes = ircnt_pkg::REF_W'(32'(commit ? nsum_q : sum_q)
			<< ircnt_pkg::UNIT_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= M_PRE;
			bank_q   <= 1'b0;
			used_q   <= '0;
			sum_q    <= '0;
			k_q      <= '0;
			pend_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start_valid) begin
						k_q      <= '0;
						s_q      <= d_s;
						match_q  <= 1'b0;
						mcnt_q   <= '0;
						pos_q    <= d_s;
						n_q      <= '0;
						nsum_q   <= '0;
						tch_q    <= '0;
						adding_q <= req.opcode == ircnt_pkg::OP_ADD;
						pre_q    <= ircnt_pkg::ST_NONE;
						mode_q   <= M_PRE;
						state_q  <= S_FIN;
						if (req.opcode == ircnt_pkg::OP_CHK) begin
							e_q <= d_e;
							if (d_su == '0) begin
								pre_q <= ircnt_pkg::ST_ZERO;
							end else begin
								mode_q <= M_CHECK;
								if (used_q != '0) state_q <= S_RD;
							end
						end else if (req.opcode == ircnt_pkg::OP_ADD
								|| req.opcode == ircnt_pkg::OP_REL) begin
							e_q <= d_ec;
							if (d_su == '0) begin
								pre_q <= ircnt_pkg::ST_ZERO;
							end else if (ircnt_pkg::EXT_W'(d_s) < d_ec) begin
								mode_q  <= M_BUILD;
								state_q <= (used_q != '0) ? S_RD : S_TAIL;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (mode_q == M_CHECK) begin
						if ({1'b0, rd.lo} == ircnt_pkg::EXT_W'(s_q)
								&& {1'b0, rd.hi} == e_q) begin
							match_q <= 1'b1;
							mcnt_q  <= rd.cnt;
						end
						k_q     <= k_q + ircnt_pkg::USED_W'(1);
						state_q <= last_k ? S_FIN : S_RD;
					end else begin
						pc_q[0] <= '{lo: pos_q, hi: gap_hi, cnt: ONE};
						pc_q[1] <= ovl ? '{lo: rd.lo, hi: lo_v, cnt: rd.cnt} : rd;
						pc_q[2] <= '{lo: lo_v, hi: hi_v, cnt: nc};
						pc_q[3] <= '{lo: hi_v, hi: rd.hi, cnt: rd.cnt};
						pend_q  <= pend_v;
						tch_q   <= t_all;
						if (rd.hi > pos_q) pos_q <= rd.hi;
						// an entry released to zero with nothing around it writes no piece
						if (pend_v == 4'b0000) begin
							k_q     <= k_q + ircnt_pkg::USED_W'(1);
							state_q <= last_k ? S_TAIL : S_RD;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (!full_v) n_q <= n_q + ircnt_pkg::EMIT_W'(1);
					nsum_q <= nsum_q + (wdat.hi - wdat.lo);
					pend_q[sel] <= 1'b0;
					if ((pend_q & ~(4'b0001 << sel)) == 4'b0000) begin
						k_q     <= k_q + ircnt_pkg::USED_W'(1);
						state_q <= last_k ? S_TAIL : S_RD;
					end
				end
				S_TAIL: begin
					if (tail_v) begin
						if (!full_v) n_q <= n_q + ircnt_pkg::EMIT_W'(1);
						nsum_q <= nsum_q + (wdat.hi - wdat.lo);
						tch_q  <= touch_upd(tch_q, ONE);
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						if (commit) begin
							bank_q <= !bank_q;
							used_q <= ircnt_pkg::USED_W'(n_q);
							sum_q  <= nsum_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/interval_reference_count_table_top.sv
// interval_reference_count_table_top: interval reference-count table, top level
// depends on ircnt_pkg, ircnt_if, ircnt_ram, ircnt_seq
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    opcode, start_byte, size_bytes
//   rsp      out  valid/ready    ref_min, ref_max, status, block_matches, referenced_bytes
//
// one request at a time; an add or release is accepted, then reads and merges each stored
// entry in turn (read, merge) and writes its pieces (none to four per entry), then runs
// tail and finish; the single read port of the active bank sets the pace of this walk.
// a check is accepted, then reads and compares each stored entry in turn, then finishes.
// reset clears the entry count, the bank select and the byte total; the banks are not cleared.
// a finished response waits in the output register, so the next request is taken
// while rsp is stalled; only the response after that waits for rsp.ready.
`timescale 1ns / 1ps
`default_nettype none
module interval_reference_count_table_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ircnt_req_if.sink   req,
	ircnt_rsp_if.source rsp
);
	logic                          start_ready;
	logic                          res_valid;
	logic                          res_ready;
	ircnt_pkg::rsp_t               res;
	logic [ircnt_pkg::IDX_W-1:0]   rd_addr;
	ircnt_pkg::entry_t             rd_data_a, rd_data_b;
	ircnt_pkg::mem_wr_t            wr;
	logic                          rsp_vld_q;
	ircnt_pkg::rsp_t               rsp_q;

	// two banks: one holds the live table, the other takes the rebuilt one
	ircnt_ram #(.WIDTH(ircnt_pkg::ENTRY_W), .DEPTH(ircnt_pkg::MAX_ENTRIES)) u_bank_a (
		.clk   (clk),
		.we    (wr.we_a),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (rd_addr),
		.rdata (rd_data_a)
	);

	ircnt_ram #(.WIDTH(ircnt_pkg::ENTRY_W), .DEPTH(ircnt_pkg::MAX_ENTRIES)) u_bank_b (
		.clk   (clk),
		.we    (wr.we_b),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (rd_addr),
		.rdata (rd_data_b)
	);

	ircnt_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_valid (req.valid),
		.start_ready (start_ready),
		.req         (req.payload),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.rd_addr     (rd_addr),
		.rd_data_a   (rd_data_a),
		.rd_data_b   (rd_data_b),
		.wr          (wr)
	);

	assign req.ready = start_ready;

	// output register frees the sequencer once the response is captured
	assign res_ready = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid   = rsp_vld_q;
	assign rsp.payload = rsp_q;
endmodule
`default_nettype wire

// File: rtl/ircnt_chk.sv
// ircnt_chk: port-level checks on the response channel, bound to the top level
// depends on ircnt_pkg, interval_reference_count_table_top
`timescale 1ns / 1ps
`default_nettype none
module ircnt_chk (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            rsp_valid,
	input wire logic            rsp_ready,
	input wire ircnt_pkg::rsp_t rsp_payload
);
	// a stalled response keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("response changed while stalled");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status == ircnt_pkg::ST_ZERO
		|-> rsp_payload.ref_min == '0 && rsp_payload.ref_max == '0
			&& !rsp_payload.block_matches)
		else $error("zero-size response carries counts");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status == ircnt_pkg::ST_FULL
		|-> rsp_payload.ref_min == '0 && rsp_payload.ref_max == '0)
		else $error("table-full response carries counts");

	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.block_matches
		|-> rsp_payload.status == ircnt_pkg::ST_OK
			&& rsp_payload.ref_min == rsp_payload.ref_max)
		else $error("match without ok status");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_payload.ref_min <= rsp_payload.ref_max)
		else $error("minimum count above maximum");
endmodule

bind interval_reference_count_table_top ircnt_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
`default_nettype wire

// File: dv/tb_interval_reference_count_table_top.sv
// tb_interval_reference_count_table_top: self-checking bench for the interval reference-count table
// depends on ircnt_pkg, ircnt_if and the rtl top level
`timescale 1ns / 1ps
`default_nettype none

// holds the predicted interval table and the queue of responses still owed by the block
class refcount_scoreboard;
	logic [11:0] lo_tab [ircnt_pkg::MAX_ENTRIES];
	logic [11:0] hi_tab [ircnt_pkg::MAX_ENTRIES];
	logic [7:0]  cnt_tab[ircnt_pkg::MAX_ENTRIES];
	int          n_used;
	ircnt_pkg::rsp_t pending_rsp[$];
	int          errors;

	function new();
		n_used = 0;
		errors = 0;
	endfunction

	function logic [19:0] table_bytes();
		int unsigned sum;
		sum = 0;
		for (int k = 0; k < n_used; k++)
			sum += hi_tab[k] - lo_tab[k];
		return 20'(sum << ircnt_pkg::UNIT_SHIFT);
	endfunction

	// rebuild the table for one accepted request and queue the expected response
	function void note_request(ircnt_pkg::req_t r);
		ircnt_pkg::rsp_t exp;
		int unsigned s, e, su, pos, a, b, c, lo, hi, nc, np;
		int unsigned nlo[$], nhi[$], ncnt[$];
		int unsigned tmin, tmax;
		bit touched;
		exp = '0;
		exp.status = ircnt_pkg::ST_NONE;
		s = r.start_byte >> ircnt_pkg::UNIT_SHIFT;
		su = (r.size_bytes + (1 << ircnt_pkg::UNIT_SHIFT) - 1) >> ircnt_pkg::UNIT_SHIFT;
		e = s + su;
		touched = 0;
		tmin = 0;
		tmax = 0;
		if (r.opcode == ircnt_pkg::OP_CHK) begin
			if (su == 0) exp.status = ircnt_pkg::ST_ZERO;
			else for (int k = 0; k < n_used; k++)
				if (lo_tab[k] == s && hi_tab[k] == e) begin
					exp.block_matches = 1'b1;
					exp.status = ircnt_pkg::ST_OK;
					exp.ref_min = cnt_tab[k];
					exp.ref_max = cnt_tab[k];
				end
		end else if (r.opcode == ircnt_pkg::OP_ADD || r.opcode == ircnt_pkg::OP_REL) begin
			if (su == 0) exp.status = ircnt_pkg::ST_ZERO;
			else begin
				if (e > ircnt_pkg::HEAP_UNITS) e = ircnt_pkg::HEAP_UNITS;
				if (s < e) begin
					pos = s;
					for (int k = 0; k < n_used; k++) begin
						a = lo_tab[k];
						b = hi_tab[k];
						c = cnt_tab[k];
						lo = a > s ? a : s;
						hi = b < e ? b : e;
						if (r.opcode == ircnt_pkg::OP_ADD && pos < e && a > pos) begin
							nlo.push_back(pos);
							nhi.push_back(a < e ? a : e);
							ncnt.push_back(1);
							if (!touched || tmin > 1) tmin = 1;
							if (!touched || tmax < 1) tmax = 1;
							touched = 1;
						end
						if (lo < hi) begin
							if (a < lo) begin
								nlo.push_back(a); nhi.push_back(lo); ncnt.push_back(c);
							end
							if (r.opcode == ircnt_pkg::OP_ADD) nc = c < 255 ? c + 1 : c;
							else nc = c > 0 ? c - 1 : 0;
							if (nc != 0) begin
								nlo.push_back(lo); nhi.push_back(hi); ncnt.push_back(nc);
							end
							if (!touched || nc < tmin) tmin = nc;
							if (!touched || nc > tmax) tmax = nc;
							touched = 1;
							if (hi < b) begin
								nlo.push_back(hi); nhi.push_back(b); ncnt.push_back(c);
							end
						end else begin
							nlo.push_back(a); nhi.push_back(b); ncnt.push_back(c);
						end
						if (b > pos) pos = b;
					end
					if (r.opcode == ircnt_pkg::OP_ADD && pos < e) begin
						nlo.push_back(pos); nhi.push_back(e); ncnt.push_back(1);
						if (!touched || tmin > 1) tmin = 1;
						if (!touched || tmax < 1) tmax = 1;
						touched = 1;
					end
					np = nlo.size();
					if (np > ircnt_pkg::MAX_ENTRIES) exp.status = ircnt_pkg::ST_FULL;
					else if (touched) begin
						for (int k = 0; k < np; k++) begin
							lo_tab[k] = 12'(nlo[k]);
							hi_tab[k] = 12'(nhi[k]);
							cnt_tab[k] = 8'(ncnt[k]);
						end
						n_used = np;
						exp.status = ircnt_pkg::ST_OK;
						exp.ref_min = 8'(tmin);
						exp.ref_max = 8'(tmax);
					end
				end
			end
		end
		exp.referenced_bytes = table_bytes();
		pending_rsp.push_back(exp);
	endfunction

	function void check_response(ircnt_pkg::rsp_t act);
		ircnt_pkg::rsp_t exp;
		if (pending_rsp.size() == 0) begin
			$display("%0t: response with nothing outstanding: %h", $realtime, act);
			errors++;
			return;
		end
		exp = pending_rsp.pop_front();
		if (act.ref_min !== exp.ref_min) begin
			$display("%0t: ref_min expected %0d got %0d", $realtime, exp.ref_min, act.ref_min);
			errors++;
		end
		if (act.ref_max !== exp.ref_max) begin
			$display("%0t: ref_max expected %0d got %0d", $realtime, exp.ref_max, act.ref_max);
			errors++;
		end
		if (act.status !== exp.status) begin
			$display("%0t: status expected %0d got %0d", $realtime, exp.status, act.status);
			errors++;
		end
		if (act.block_matches !== exp.block_matches) begin
			$display("%0t: block_matches expected %0d got %0d", $realtime,
				exp.block_matches, act.block_matches);
			errors++;
		end
		if (act.referenced_bytes !== exp.referenced_bytes) begin
			$display("%0t: referenced_bytes expected %0d got %0d", $realtime,
				exp.referenced_bytes, act.referenced_bytes);
			errors++;
		end
	endfunction
endclass

module tb_interval_reference_count_table_top;

	localparam int RANDOM_REQS = 1350;
	localparam longint CYCLE_LIMIT = 5000000;

	logic clk;
	logic arst_n;
	ircnt_req_if req ();
	ircnt_rsp_if rsp ();

	interval_reference_count_table_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	refcount_scoreboard table_model;
	bit     stim_done;
	bit     calm_phase;     // no idling on either side near the end
	bit     hold_rsp;       // long back-pressure stretch on the response side
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		table_model = new();
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// cycle watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// response side: accept, check, and stall in random bursts
	initial begin
		int idle;
		idle = 0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				table_model.check_response(rsp.payload);
			if (hold_rsp)
				rsp.ready <= 1'b0;
			else if (!calm_phase && idle == 0 && $urandom_range(0, 5) == 0)
				idle = $urandom_range(1, 4);
			if (!hold_rsp) begin
				if (idle > 0) begin
					rsp.ready <= 1'b0;
					idle--;
				end else
					rsp.ready <= 1'b1;
			end
		end
	end

	// send one request; outside the calm phase a random idle gap may precede it
	task automatic send_request(input logic [1:0] op, input logic [18:0] sb,
			input logic [19:0] zb);
		ircnt_pkg::req_t r;
		if (!calm_phase && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		r.opcode = op;
		r.start_byte = sb;
		r.size_bytes = zb;
		req.valid <= 1'b1;
		req.payload <= r;
		do @(posedge clk); while (!req.ready);
		table_model.note_request(r);
	endtask

	// mostly small aligned ranges inside a narrow window so that entries overlap and build up
	task automatic send_random();
		logic [1:0] op;
		logic [18:0] sb;
		logic [19:0] zb;
		int pick;
		pick = $urandom_range(0, 99);
		op = pick < 50 ? ircnt_pkg::OP_ADD : (pick < 85 ? ircnt_pkg::OP_REL :
			(pick < 97 ? ircnt_pkg::OP_CHK : 2'd3));
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			sb = 19'($urandom_range(0, 40) << ircnt_pkg::UNIT_SHIFT) |
				19'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 0);
			zb = 20'($urandom_range(1, 8) << ircnt_pkg::UNIT_SHIFT) -
				20'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 0);
		end else if (pick < 95) begin
			sb = 19'($urandom);
			zb = 20'($urandom_range(0, 1 << 16));
		end else begin
			sb = 19'($urandom);
			zb = 20'($urandom);
			if (zb > 20'h80000) zb = 20'h80000;
		end
		send_request(op, sb, zb);
	endtask

	initial begin
		stim_done = 0;
		calm_phase = 0;
		hold_rsp = 0;
		req.valid = 1'b0;
		req.payload = '0;
		@(posedge arst_n);
		@(posedge clk);

		// directed: zero size, heap edges, saturation, unused opcode, check hit and miss
		send_request(ircnt_pkg::OP_ADD, 19'd0, 20'd0);
		send_request(ircnt_pkg::OP_CHK, 19'd0, 20'd0);
		send_request(ircnt_pkg::OP_REL, 19'd512, 20'd256);      // nothing touched
		send_request(ircnt_pkg::OP_ADD, 19'd256, 20'd1);        // size rounds up to one unit
		send_request(ircnt_pkg::OP_CHK, 19'd256, 20'd256);      // exact hit
		send_request(ircnt_pkg::OP_CHK, 19'd0, 20'd512);        // miss
		send_request(ircnt_pkg::OP_ADD, 19'd0, 20'd1024);       // splits and fills gaps
		send_request(ircnt_pkg::OP_ADD, 19'h7FFFF, 20'h80000);  // clipped at the heap end
		send_request(ircnt_pkg::OP_ADD, 19'h7FF00, 20'hFFFFF);
		send_request(2'd3, 19'h7FFFF, 20'hFFFFF);               // unused opcode
		send_request(ircnt_pkg::OP_REL, 19'd0, 20'h80000);      // release whole heap
		send_request(ircnt_pkg::OP_REL, 19'd0, 20'h80000);
		send_request(ircnt_pkg::OP_REL, 19'd0, 20'h80000);
		for (int k = 0; k < 258; k++)                           // push one count to saturation
			send_request(ircnt_pkg::OP_ADD, 19'd2048, 20'd256);
		send_request(ircnt_pkg::OP_CHK, 19'd2048, 20'd256);
		// overflow: many single-unit entries with gaps
		for (int k = 0; k < 70; k++)
			send_request(ircnt_pkg::OP_ADD, 19'((k * 2 + 20) << ircnt_pkg::UNIT_SHIFT),
				20'd256);
		send_request(ircnt_pkg::OP_ADD, 19'd0, 20'h80000);      // would need too many entries
		send_request(ircnt_pkg::OP_REL, 19'd0, 20'h80000);

		// back-pressure: response side held while requests keep coming
		fork
			begin
				hold_rsp = 1;
				repeat (1000) @(posedge clk);
				hold_rsp = 0;
			end
			for (int k = 0; k < 8; k++) send_random();
		join

		for (int k = 0; k < RANDOM_REQS; k++) begin
			if (k == RANDOM_REQS - 200) calm_phase = 1;
			if (k % 300 == 299) send_request(ircnt_pkg::OP_REL, 19'd0, 20'h80000);
			send_random();
		end
		req.valid <= 1'b0;
		stim_done = 1;
	end

	// end of run: drain outstanding responses, then a short settle
	initial begin
		wait (stim_done);
		while (table_model.pending_rsp.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (table_model.errors == 0 && table_model.pending_rsp.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
rtl/ircnt_pkg.sv
rtl/ircnt_if.sv
rtl/ircnt_ram.sv
rtl/ircnt_seq.sv
rtl/interval_reference_count_table_top.sv
rtl/ircnt_chk.sv
dv/tb_interval_reference_count_table_top.sv
